@@ rtl/mct_pkg.sv @@
// Shared types and constants of the MIDI channel transposer.
`timescale 1ns / 1ps
package mct_pkg;

    localparam int MAP_ADDR_W  = 11;
    localparam int MAP_DEPTH   = 2048;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] DRUM_CHANNEL = 4'd9;
    localparam logic [7:0] NO_NOTE      = 8'h80;

    // Map command codes
    localparam logic [1:0] FN_MSG    = 2'd0;
    localparam logic [1:0] FN_CLR_ALL = 2'd1;
    localparam logic [1:0] FN_CLR_CH = 2'd2;

    // MIDI status nibbles
    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_POLY_PRESS = 4'hA;
    localparam logic [3:0] ST_CONTROL    = 4'hB;
    localparam logic [3:0] ST_PROGRAM    = 4'hC;
    localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
    localparam logic [3:0] ST_BEND       = 4'hE;

    // Configuration register indexes
    localparam logic CFG_TRANSPOSE = 1'b0;
    localparam logic CFG_MUTE_MASK = 1'b1;

    typedef enum logic [3:0] {
        MC_NONE,
        MC_NOTE_ON,
        MC_NOTE_OFF,
        MC_POLY_PRESS,
        MC_CONTROL,
        MC_PROGRAM,
        MC_CHAN_PRESS,
        MC_BEND,
        MC_CLR_ALL,
        MC_CLR_CH
    } t_msg_class;

    typedef enum logic [2:0] {
        OK_NOTE_ON    = 3'd0,
        OK_NOTE_OFF   = 3'd1,
        OK_CONTROL    = 3'd2,
        OK_PROGRAM    = 3'd3,
        OK_CHAN_PRESS = 3'd4,
        OK_KEY_PRESS  = 3'd5,
        OK_BEND       = 3'd6
    } t_out_kind;

    typedef struct packed {
        t_out_kind  kind;
        logic [3:0] channel;
        logic [6:0] first;
        logic [6:0] second;
    } t_q_entry;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_stat;

    typedef struct packed {
        logic sweep_busy;
        logic clear_pending;
    } t_front_stat;

endpackage

@@ rtl/mct_msg_if.sv @@
// Input channel carrying MIDI channel messages and map commands.
`timescale 1ns / 1ps
interface mct_msg_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] status_kind;
    logic [3:0] channel;
    logic [6:0] data_first;
    logic [6:0] data_second;

    modport source (
        output valid, func, status_kind, channel, data_first, data_second,
        input  ready
    );
    modport sink (
        input  valid, func, status_kind, channel, data_first, data_second,
        output ready
    );
endinterface

@@ rtl/mct_evt_if.sv @@
// Output channel carrying emitted MIDI events.
`timescale 1ns / 1ps
interface mct_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [3:0]  out_channel;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic [13:0] out_bend;

    modport source (
        output valid, out_kind, out_channel, out_first, out_second, out_bend,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_channel, out_first, out_second, out_bend,
        output ready
    );
endinterface

@@ rtl/mct_front.sv @@
// Front end: accept, classify, note map lookup and update, map clearing.
`timescale 1ns / 1ps
module mct_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    mct_msg_if.sink                i_msg,
    input  mct_pkg::t_q_stat       i_q_stat,
    output logic                   o_push,
    output mct_pkg::t_q_entry      o_push_entry,
    output mct_pkg::t_front_stat   o_stat
);
    import mct_pkg::*;

    logic [5:0]            r_transpose;
    logic [15:0]           r_mute_mask;

    logic [7:0]            r_map [MAP_DEPTH];
    logic [7:0]            r_map_rd;

    logic                  r_s1_valid;
    t_msg_class            r_s1_class;
    logic [3:0]            r_s1_ch;
    logic [6:0]            r_s1_d1;
    logic [6:0]            r_s1_d2;

    logic                  r_byp_valid;
    logic [MAP_ADDR_W-1:0] r_byp_addr;
    logic [7:0]            r_byp_data;

    logic                  r_sweep_busy;
    logic                  r_sweep_all;
    logic [MAP_ADDR_W-1:0] r_sweep_addr;

    t_msg_class            n_class;
    logic                  w_accept;
    logic                  w_clear_pending;
    logic [QCNT_W-1:0]     w_fill;
    logic [MAP_ADDR_W-1:0] w_rd_slot;
    logic [MAP_ADDR_W-1:0] w_s1_slot;
    logic [7:0]            w_entry;
    logic [6:0]            w_recorded;
    logic [8:0]            w_pitch;
    logic                  w_in_range;
    logic                  w_muted;
    logic                  w_item_we;
    logic [7:0]            w_item_wdata;
    logic                  w_sweep_last;
    logic                  w_map_we;
    logic [MAP_ADDR_W-1:0] w_map_waddr;
    logic [7:0]            w_map_wdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= '0;
            r_mute_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRANSPOSE: r_transpose <= i_cfg_data[5:0];
                CFG_MUTE_MASK: r_mute_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold off new transactions while a clear is queued or sweeping, or the queue may overflow
    assign w_clear_pending = r_s1_valid &&
                             (r_s1_class == MC_CLR_ALL || r_s1_class == MC_CLR_CH);
    assign w_fill          = i_q_stat.count + QCNT_W'(r_s1_valid);
    assign i_msg.ready     = !r_sweep_busy && !w_clear_pending &&
                             (w_fill < QCNT_W'(QUEUE_DEPTH));
    assign w_accept        = i_msg.valid && i_msg.ready;

    always_comb begin
        n_class = MC_NONE;
        unique case (i_msg.func)
            FN_MSG: begin
                unique case (i_msg.status_kind)
                    ST_NOTE_OFF:   n_class = MC_NOTE_OFF;
                    ST_NOTE_ON:    n_class = (i_msg.data_second != 7'd0) ? MC_NOTE_ON
                                                                         : MC_NOTE_OFF;
                    ST_POLY_PRESS: n_class = MC_POLY_PRESS;
                    ST_CONTROL:    n_class = MC_CONTROL;
                    ST_PROGRAM:    n_class = MC_PROGRAM;
                    ST_CHAN_PRESS: n_class = MC_CHAN_PRESS;
                    ST_BEND:       n_class = MC_BEND;
                    default:       n_class = MC_NONE;
                endcase
            end
            FN_CLR_ALL: n_class = MC_CLR_ALL;
            FN_CLR_CH:  n_class = MC_CLR_CH;
            default:    n_class = MC_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_class <= n_class;
            r_s1_ch    <= i_msg.channel;
            r_s1_d1    <= i_msg.data_first;
            r_s1_d2    <= i_msg.data_second;
        end
    end

    // Note map: one write port, one registered read port
    assign w_rd_slot = {i_msg.channel, i_msg.data_first};

    always_ff @(posedge i_clk) begin
        r_map_rd <= r_map[w_rd_slot];
        if (w_map_we) begin
            r_map[w_map_waddr] <= w_map_wdata;
        end
    end

    // Forward the write of the previous transaction, which the read missed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else begin
            r_byp_valid <= w_item_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_addr <= w_s1_slot;
        r_byp_data <= w_item_wdata;
    end

    assign w_s1_slot  = {r_s1_ch, r_s1_d1};
    assign w_entry    = (r_byp_valid && r_byp_addr == w_s1_slot) ? r_byp_data : r_map_rd;
    assign w_recorded = w_entry[7] ? r_s1_d1 : w_entry[6:0];

    assign w_pitch    = {2'b00, r_s1_d1} +
                        ((r_s1_ch == DRUM_CHANNEL) ? 9'd0
                                                   : {{3{r_transpose[5]}}, r_transpose});
    assign w_in_range = (w_pitch[8:7] == 2'b00);
    assign w_muted    = r_mute_mask[r_s1_ch];

    always_comb begin
        o_push              = 1'b0;
        o_push_entry.kind    = OK_NOTE_ON;
        o_push_entry.channel = r_s1_ch;
        o_push_entry.first   = r_s1_d1;
        o_push_entry.second  = r_s1_d2;
        w_item_we           = 1'b0;
        w_item_wdata        = NO_NOTE;
        if (r_s1_valid) begin
            unique case (r_s1_class)
                MC_NOTE_ON: begin
                    if (!w_muted && w_in_range) begin
                        o_push             = 1'b1;
                        o_push_entry.first = w_pitch[6:0];
                        w_item_we          = 1'b1;
                        w_item_wdata       = {1'b0, w_pitch[6:0]};
                    end
                end
                MC_NOTE_OFF: begin
                    o_push             = 1'b1;
                    o_push_entry.kind  = OK_NOTE_OFF;
                    o_push_entry.first = w_recorded;
                    w_item_we          = 1'b1;
                end
                MC_POLY_PRESS: begin
                    o_push             = 1'b1;
                    o_push_entry.kind  = OK_KEY_PRESS;
                    o_push_entry.first = w_recorded;
                end
                MC_CONTROL: begin
                    o_push            = 1'b1;
                    o_push_entry.kind = OK_CONTROL;
                end
                MC_PROGRAM: begin
                    o_push            = 1'b1;
                    o_push_entry.kind = OK_PROGRAM;
                end
                MC_CHAN_PRESS: begin
                    o_push            = 1'b1;
                    o_push_entry.kind = OK_CHAN_PRESS;
                end
                MC_BEND: begin
                    o_push            = 1'b1;
                    o_push_entry.kind = OK_BEND;
                end
                default: ;
            endcase
        end
    end

    // Clearing sweep: whole map after reset and on clear-all, one row on clear-channel
    assign w_sweep_last = r_sweep_all ? (&r_sweep_addr) : (&r_sweep_addr[6:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_busy <= 1'b1;
            r_sweep_all  <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweep_busy) begin
            r_sweep_addr <= r_sweep_addr + MAP_ADDR_W'(1);
            if (w_sweep_last) begin
                r_sweep_busy <= 1'b0;
            end
        end else if (r_s1_valid && r_s1_class == MC_CLR_ALL) begin
            r_sweep_busy <= 1'b1;
            r_sweep_all  <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_s1_valid && r_s1_class == MC_CLR_CH) begin
            r_sweep_busy <= 1'b1;
            r_sweep_all  <= 1'b0;
            r_sweep_addr <= {r_s1_ch, 7'd0};
        end
    end

    assign w_map_we    = r_sweep_busy || w_item_we;
    assign w_map_waddr = r_sweep_busy ? r_sweep_addr : w_s1_slot;
    assign w_map_wdata = r_sweep_busy ? NO_NOTE : w_item_wdata;

    assign o_stat.sweep_busy    = r_sweep_busy;
    assign o_stat.clear_pending = w_clear_pending;

endmodule

@@ rtl/mct_queue.sv @@
// Short queue of resolved events between front and back end.
`timescale 1ns / 1ps
module mct_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mct_pkg::t_q_entry   i_push_entry,
    input  logic                i_pop,
    output mct_pkg::t_q_entry   o_head,
    output mct_pkg::t_q_stat    o_stat
);
    import mct_pkg::*;

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

@@ rtl/mct_back.sv @@
// Back end: shapes queued events into output fields and holds the output register.
`timescale 1ns / 1ps
module mct_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mct_pkg::t_q_entry   i_head,
    input  mct_pkg::t_q_stat    i_q_stat,
    output logic                o_pop,
    mct_evt_if.source           o_evt
);
    import mct_pkg::*;

    logic        r_valid;
    t_out_kind   r_kind;
    logic [3:0]  r_channel;
    logic [6:0]  r_first;
    logic [6:0]  r_second;
    logic [13:0] r_bend;

    logic [6:0]  n_first;
    logic [6:0]  n_second;
    logic [13:0] n_bend;

    // Advance whenever the output register is free or being emptied
    assign o_pop = !i_q_stat.empty && (!r_valid || o_evt.ready);

    always_comb begin
        n_first  = i_head.first;
        n_second = 7'd0;
        n_bend   = 14'd0;
        case (i_head.kind) inside
            OK_NOTE_ON, OK_CONTROL, OK_KEY_PRESS: begin
                n_second = i_head.second;
            end
            OK_BEND: begin
                n_first = 7'd0;
                n_bend  = {i_head.second, i_head.first};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_head.kind;
            r_channel <= i_head.channel;
            r_first   <= n_first;
            r_second  <= n_second;
            r_bend    <= n_bend;
        end
    end

    assign o_evt.valid       = r_valid;
    assign o_evt.out_kind    = r_kind;
    assign o_evt.out_channel = r_channel;
    assign o_evt.out_first   = r_first;
    assign o_evt.out_second  = r_second;
    assign o_evt.out_bend    = r_bend;

endmodule

@@ rtl/midi_channel_transposer_top.sv @@
// MIDI channel transposer with per-key note tracking: top level.
//
// Takes one MIDI channel message or map command per clock unless a clear or
// a full queue holds it off, and emits at most one event for it via s1, the
// queue and the output register. A message that follows in the next cycle
// is accepted while earlier ones are in flight, so the sustained rate is
// one transaction per clock; the 2048-entry note map is read once and
// written at most once per transaction and its read is forwarded past the
// previous transaction's write. A four-entry queue separates map handling
// from the output register, so the input keeps flowing while a result
// waits. The map's single write port also clears it: the input is held off
// while all 2048 entries are cleared after reset or on a clear-all command,
// or one channel's 128 entries on a clear-channel command. Configuration is
// written through i_cfg_we, i_cfg_index and i_cfg_data: index 0 is the
// signed transpose, index 1 the per-channel mute mask.
`timescale 1ns / 1ps
module midi_channel_transposer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    mct_msg_if.sink     i_msg,
    mct_evt_if.source   o_evt
);
    import mct_pkg::*;

    logic        w_push;
    t_q_entry    w_push_entry;
    t_q_entry    w_head;
    t_q_stat     w_q_stat;
    t_front_stat w_front_stat;
    logic        w_pop;

    mct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_msg        (i_msg),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_push_entry (w_push_entry),
        .o_stat       (w_front_stat)
    );

    mct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_stat       (w_q_stat)
    );

    mct_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_evt    (o_evt)
    );

    // The queue never overflows: the front end reserves room before it accepts
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("event pushed into a full queue");

    // Reset always starts a full clearing sweep of the note map
    a_reset_sweep : assert property (@(posedge i_clk)
        !i_rst_n |=> w_front_stat.sweep_busy)
        else $error("no clearing sweep after reset");

    // No transaction is taken while the map is being cleared
    a_sweep_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_front_stat.sweep_busy || w_front_stat.clear_pending) |-> !i_msg.ready)
        else $error("input ready during map clear");

    // An event appears only after it has been queued
    a_out_from_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_evt.valid) |-> $past(!w_q_stat.empty))
        else $error("output event without queued source");

endmodule
